>>> rtl/core/cch_tc_pkg.sv
package cch_tc_pkg;

	localparam int REQ_W   = 3;
	localparam int IDX_W   = 13;
	localparam int HEAD_W  = 10;
	localparam int WIN_W   = 32;
	localparam int VC_W    = 11;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;

	localparam logic [REQ_W-1:0] REQ_LOAD_OFF  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_EDGE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RUN       = 3'd2;
	localparam logic [REQ_W-1:0] REQ_READ      = 3'd3;

	typedef enum logic [1:0] {
		OP_LOAD_OFF  = 2'd0,
		OP_LOAD_EDGE = 2'd1,
		OP_RUN       = 2'd2,
		OP_READ      = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              idx_ok;
		logic [IDX_W-1:0]  idx;
		logic [IDX_W-1:0]  offset;
		logic [HEAD_W-1:0] head;
		logic [WIN_W-1:0]  upw;
		logic [WIN_W-1:0]  dnw;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

>>> rtl/core/cch_tc_ram.sv
module cch_tc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/cch_tc_front.sv
module cch_tc_front #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [cch_tc_pkg::REQ_W-1:0]   req_type,
	input  logic [cch_tc_pkg::IDX_W-1:0]   item_index,
	input  logic [cch_tc_pkg::IDX_W-1:0]   offset_value,
	input  logic [cch_tc_pkg::HEAD_W-1:0]  edge_head,
	input  logic [cch_tc_pkg::WIN_W-1:0]   up_weight_in,
	input  logic [cch_tc_pkg::WIN_W-1:0]   down_weight_in,
	input  cch_tc_pkg::back_stat_t         stat,
	output logic                           cmd_valid,
	output cch_tc_pkg::cmd_t               cmd,
	input  logic                           cmd_pop
);

	cch_tc_pkg::cmd_t                    q_q [cch_tc_pkg::QDEPTH];
	logic [cch_tc_pkg::QPTR_W-1:0]       wptr_q, rptr_q;
	logic [cch_tc_pkg::QPTR_W:0]         cnt_q;
	cch_tc_pkg::cmd_t                    new_cmd;
	logic                                known;
	logic                                acc;
	logic                                deq;

	always_comb begin
		new_cmd        = '0;
		known          = 1'b1;
		new_cmd.idx    = item_index;
		new_cmd.offset = offset_value;
		new_cmd.head   = edge_head;
		new_cmd.upw    = up_weight_in;
		new_cmd.dnw    = down_weight_in;
		new_cmd.op     = cch_tc_pkg::OP_RUN;
		case (req_type)
			cch_tc_pkg::REQ_LOAD_OFF: begin
				new_cmd.op     = cch_tc_pkg::OP_LOAD_OFF;
				new_cmd.idx_ok = 32'(item_index) <= 32'(MAX_VERTICES);
			end
			cch_tc_pkg::REQ_LOAD_EDGE: begin
				new_cmd.op     = cch_tc_pkg::OP_LOAD_EDGE;
				new_cmd.idx_ok = 32'(item_index) < 32'(MAX_EDGES);
			end
			cch_tc_pkg::REQ_RUN: begin
				new_cmd.op = cch_tc_pkg::OP_RUN;
			end
			cch_tc_pkg::REQ_READ: begin
				new_cmd.op     = cch_tc_pkg::OP_READ;
				new_cmd.idx_ok = 32'(item_index) < 32'(MAX_EDGES);
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign full      = stat.clearing || (32'(cnt_q) == 32'(cch_tc_pkg::QDEPTH));
	assign acc       = push && !full;
	assign cmd_valid = cnt_q != '0;
	assign cmd       = q_q[rptr_q];
	assign deq       = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (acc && known) begin
			q_q[wptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (acc && known) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (deq) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if ((acc && known) && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(acc && known) && deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/cch_tc_back.sv
module cch_tc_back #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cch_tc_pkg::VC_W-1:0]   vertex_count,
	input  logic                          cmd_valid,
	input  cch_tc_pkg::cmd_t              cmd,
	output logic                          cmd_pop,
	output cch_tc_pkg::back_stat_t        stat,
	output logic                          empty,
	input  logic                          pop,
	output logic                          status,
	output logic [cch_tc_pkg::WIN_W-1:0]  up_weight_out,
	output logic [cch_tc_pkg::WIN_W-1:0]  down_weight_out,
	output logic [cch_tc_pkg::IDX_W-1:0]  up_via_first,
	output logic [cch_tc_pkg::IDX_W-1:0]  up_via_second,
	output logic [cch_tc_pkg::IDX_W-1:0]  down_via_first,
	output logic [cch_tc_pkg::IDX_W-1:0]  down_via_second
);

	localparam int EAW = $clog2(MAX_EDGES);
	localparam int EIW = $clog2(MAX_EDGES + 1);
	localparam int VAW = $clog2(MAX_VERTICES + 1);
	localparam int WB  = WEIGHT_BITS;
	localparam int HW  = cch_tc_pkg::HEAD_W;
	localparam int OW  = cch_tc_pkg::IDX_W;
	localparam logic [EIW-1:0] NONE = EIW'(MAX_EDGES);

	typedef enum logic [18:0] {
		ST_CLEAR = 19'd1 << 0,
		ST_IDLE  = 19'd1 << 1,
		ST_RDW   = 19'd1 << 2,
		ST_UA    = 19'd1 << 3,
		ST_UB    = 19'd1 << 4,
		ST_UC    = 19'd1 << 5,
		ST_VA    = 19'd1 << 6,
		ST_VB    = 19'd1 << 7,
		ST_VC    = 19'd1 << 8,
		ST_VD    = 19'd1 << 9,
		ST_WA    = 19'd1 << 10,
		ST_WB    = 19'd1 << 11,
		ST_SA    = 19'd1 << 12,
		ST_SB    = 19'd1 << 13,
		ST_RA    = 19'd1 << 14,
		ST_RB    = 19'd1 << 15,
		ST_RC    = 19'd1 << 16,
		ST_RD    = 19'd1 << 17,
		ST_DONE  = 19'd1 << 18
	} state_t;

	function automatic logic [EIW-1:0] clamp_off(input logic [OW-1:0] x);
		return (32'(x) > 32'(MAX_EDGES)) ? NONE : EIW'(x);
	endfunction

	state_t          state_q;
	logic [EAW-1:0]  clr_q;
	logic            flag_q;
	logic [VAW-1:0]  n_q, u_q;
	logic [EIW-1:0]  ub_q, ue_q, uv_q, uw_q, vb_q, ve_q, pos_q;
	logic [HW-1:0]   v_q, w_q;
	logic [WB-1:0]   a_up_q, a_dn_q;
	logic [WB:0]     s_up_q, s_dn_q;
	logic            rd_ok_q;

	logic            res_valid_q;
	logic            res_status_q;
	logic [WB-1:0]   res_up_q, res_dn_q;
	logic [EIW-1:0]  res_uf_q, res_us_q, res_df_q, res_ds_q;

	logic            off_we, off_re;
	logic [VAW-1:0]  off_waddr, off_raddr;
	logic [OW-1:0]   off_rd;
	logic            hd_we, hd_re;
	logic [EAW-1:0]  hd_raddr;
	logic [HW-1:0]   hd_rd;
	logic            w_we, w_re;
	logic [EAW-1:0]  w_waddr, w_raddr;
	logic [WB-1:0]   upw_wd, dnw_wd, upw_rd, dnw_rd;
	logic            upw_we, dnw_we;
	logic            wit_re;
	logic            uwit_we, dwit_we;
	logic [EAW-1:0]  wit_waddr;
	logic [2*EIW-1:0] uwit_wd, dwit_wd, uwit_rd, dwit_rd;

	logic            res_free, res_wr;
	logic            is_idle_cmd;
	logic [EIW-1:0]  c_off;
	logic            v_in;
	logic            up_better, dn_better;

	assign stat.clearing = state_q == ST_CLEAR;
	assign res_free      = !res_valid_q || pop;
	assign is_idle_cmd   = (state_q == ST_IDLE) && cmd_valid;
	assign cmd_pop       = is_idle_cmd;
	assign c_off         = clamp_off(off_rd);
	assign v_in          = 32'(hd_rd) < 32'(MAX_VERTICES);
	assign up_better     = s_up_q < {1'b0, upw_rd};
	assign dn_better     = s_dn_q < {1'b0, dnw_rd};
	assign w_we          = is_idle_cmd && (cmd.op == cch_tc_pkg::OP_LOAD_EDGE) && cmd.idx_ok;

	always_comb begin
		off_we    = is_idle_cmd && (cmd.op == cch_tc_pkg::OP_LOAD_OFF) && cmd.idx_ok;
		off_waddr = VAW'(cmd.idx);
		off_re    = 1'b0;
		off_raddr = u_q;
		hd_we     = w_we;
		hd_re     = 1'b0;
		hd_raddr  = uv_q[EAW-1:0];
		w_re      = 1'b0;
		w_waddr   = EAW'(cmd.idx);
		w_raddr   = w_waddr;
		upw_we    = w_we;
		dnw_we    = w_we;
		upw_wd    = WB'(cmd.upw);
		dnw_wd    = WB'(cmd.dnw);
		wit_re    = 1'b0;
		uwit_we   = w_we;
		dwit_we   = w_we;
		wit_waddr = EAW'(cmd.idx);
		uwit_wd   = {NONE, NONE};
		dwit_wd   = {NONE, NONE};
		res_wr    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				uwit_we   = 1'b1;
				dwit_we   = 1'b1;
				wit_waddr = clr_q;
			end
			ST_IDLE: begin
				if (is_idle_cmd && (cmd.op == cch_tc_pkg::OP_READ) && cmd.idx_ok) begin
					w_re    = 1'b1;
					wit_re  = 1'b1;
					w_raddr = EAW'(cmd.idx);
				end
			end
			ST_RDW: begin
				res_wr = res_free;
			end
			ST_UA: begin
				off_re = 1'b1;
			end
			ST_UB: begin
				off_re    = 1'b1;
				off_raddr = u_q + 1'b1;
			end
			ST_VA: begin
				hd_re = 1'b1;
			end
			ST_VB: begin
				off_re    = v_in;
				off_raddr = VAW'(hd_rd);
			end
			ST_VC: begin
				off_re    = 1'b1;
				off_raddr = VAW'(32'(v_q) + 1);
			end
			ST_WA: begin
				hd_re    = 1'b1;
				hd_raddr = uw_q[EAW-1:0];
			end
			ST_SA: begin
				hd_re    = 1'b1;
				hd_raddr = pos_q[EAW-1:0];
			end
			ST_RA: begin
				w_re    = 1'b1;
				w_raddr = uv_q[EAW-1:0];
			end
			ST_RB: begin
				w_re    = 1'b1;
				w_raddr = uw_q[EAW-1:0];
			end
			ST_RC: begin
				w_re    = 1'b1;
				w_raddr = pos_q[EAW-1:0];
			end
			ST_RD: begin
				w_waddr   = pos_q[EAW-1:0];
				wit_waddr = pos_q[EAW-1:0];
				upw_we    = up_better;
				dnw_we    = dn_better;
				uwit_we   = up_better;
				dwit_we   = dn_better;
				upw_wd    = s_up_q[WB-1:0];
				dnw_wd    = s_dn_q[WB-1:0];
				uwit_wd   = {uv_q, uw_q};
				dwit_wd   = {uw_q, uv_q};
			end
			ST_DONE: begin
				res_wr = res_free;
			end
			default: begin
			end
		endcase
	end

	cch_tc_ram #(.WIDTH(OW), .DEPTH(MAX_VERTICES + 1)) u_off_ram (
		.clk(clk), .we(off_we), .waddr(off_waddr), .wdata(cmd.offset),
		.re(off_re), .raddr(off_raddr), .rdata(off_rd)
	);

	cch_tc_ram #(.WIDTH(HW), .DEPTH(MAX_EDGES)) u_head_ram (
		.clk(clk), .we(hd_we), .waddr(EAW'(cmd.idx)), .wdata(cmd.head),
		.re(hd_re), .raddr(hd_raddr), .rdata(hd_rd)
	);

	cch_tc_ram #(.WIDTH(WB), .DEPTH(MAX_EDGES)) u_upw_ram (
		.clk(clk), .we(upw_we), .waddr(w_waddr), .wdata(upw_wd),
		.re(w_re), .raddr(w_raddr), .rdata(upw_rd)
	);

	cch_tc_ram #(.WIDTH(WB), .DEPTH(MAX_EDGES)) u_dnw_ram (
		.clk(clk), .we(dnw_we), .waddr(w_waddr), .wdata(dnw_wd),
		.re(w_re), .raddr(w_raddr), .rdata(dnw_rd)
	);

	cch_tc_ram #(.WIDTH(2 * EIW), .DEPTH(MAX_EDGES)) u_uwit_ram (
		.clk(clk), .we(uwit_we), .waddr(wit_waddr), .wdata(uwit_wd),
		.re(wit_re), .raddr(w_raddr), .rdata(uwit_rd)
	);

	cch_tc_ram #(.WIDTH(2 * EIW), .DEPTH(MAX_EDGES)) u_dwit_ram (
		.clk(clk), .we(dwit_we), .waddr(wit_waddr), .wdata(dwit_wd),
		.re(wit_re), .raddr(w_raddr), .rdata(dwit_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			flag_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(MAX_EDGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (is_idle_cmd) begin
						case (cmd.op)
							cch_tc_pkg::OP_READ: begin
								state_q <= ST_RDW;
							end
							cch_tc_pkg::OP_RUN: begin
								flag_q  <= 1'b0;
								state_q <= ST_UA;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RDW: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_UA: begin
					state_q <= (u_q >= n_q) ? ST_DONE : ST_UB;
				end
				ST_UB: begin
					state_q <= ST_UC;
				end
				ST_UC: begin
					state_q <= ST_VA;
				end
				ST_VA: begin
					state_q <= (uv_q >= ue_q) ? ST_UA : ST_VB;
				end
				ST_VB: begin
					state_q <= v_in ? ST_VC : ST_WA;
				end
				ST_VC: begin
					state_q <= ST_VD;
				end
				ST_VD: begin
					state_q <= ST_WA;
				end
				ST_WA: begin
					state_q <= (uw_q >= ue_q) ? ST_VA : ST_WB;
				end
				ST_WB: begin
					state_q <= ST_SA;
				end
				ST_SA: begin
					if (pos_q >= ve_q) begin
						flag_q  <= 1'b1;
						state_q <= ST_WA;
					end else begin
						state_q <= ST_SB;
					end
				end
				ST_SB: begin
					state_q <= (hd_rd == w_q) ? ST_RA : ST_SA;
				end
				ST_RA: begin
					state_q <= ST_RB;
				end
				ST_RB: begin
					state_q <= ST_RC;
				end
				ST_RC: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_WA;
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rd_ok_q <= cmd.idx_ok;
				u_q     <= '0;
				n_q     <= (32'(vertex_count) > 32'(MAX_VERTICES)) ?
					VAW'(MAX_VERTICES) : VAW'(vertex_count);
			end
			ST_UB: begin
				ub_q <= c_off;
			end
			ST_UC: begin
				ue_q <= (c_off < ub_q) ? ub_q : c_off;
				uv_q <= ub_q;
			end
			ST_VA: begin
				if (uv_q >= ue_q) begin
					u_q <= u_q + 1'b1;
				end
			end
			ST_VB: begin
				v_q  <= hd_rd;
				uw_q <= uv_q + 1'b1;
				if (!v_in) begin
					ve_q  <= '0;
					pos_q <= '0;
				end
			end
			ST_VC: begin
				vb_q <= c_off;
			end
			ST_VD: begin
				ve_q  <= (c_off < vb_q) ? vb_q : c_off;
				pos_q <= vb_q;
			end
			ST_WA: begin
				if (uw_q >= ue_q) begin
					uv_q <= uv_q + 1'b1;
				end
			end
			ST_WB: begin
				w_q <= hd_rd;
			end
			ST_SA: begin
				if (pos_q >= ve_q) begin
					uw_q <= uw_q + 1'b1;
				end
			end
			ST_SB: begin
				if (hd_rd != w_q) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			ST_RB: begin
				a_up_q <= upw_rd;
				a_dn_q <= dnw_rd;
			end
			ST_RC: begin
				s_up_q <= {1'b0, a_dn_q} + {1'b0, upw_rd};
				s_dn_q <= {1'b0, a_up_q} + {1'b0, dnw_rd};
			end
			ST_RD: begin
				uw_q <= uw_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_wr) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_status_q <= flag_q;
			if ((state_q == ST_RDW) && rd_ok_q) begin
				res_up_q <= upw_rd;
				res_dn_q <= dnw_rd;
				res_uf_q <= uwit_rd[2*EIW-1:EIW];
				res_us_q <= uwit_rd[EIW-1:0];
				res_df_q <= dwit_rd[2*EIW-1:EIW];
				res_ds_q <= dwit_rd[EIW-1:0];
			end else begin
				res_up_q <= '0;
				res_dn_q <= '0;
				res_uf_q <= NONE;
				res_us_q <= NONE;
				res_df_q <= NONE;
				res_ds_q <= NONE;
			end
		end
	end

	assign empty           = !res_valid_q;
	assign status          = res_status_q;
	assign up_weight_out   = cch_tc_pkg::WIN_W'(res_up_q);
	assign down_weight_out = cch_tc_pkg::WIN_W'(res_dn_q);
	assign up_via_first    = OW'(res_uf_q);
	assign up_via_second   = OW'(res_us_q);
	assign down_via_first  = OW'(res_df_q);
	assign down_via_second = OW'(res_ds_q);

endmodule

>>> rtl/core/cch_triangle_customizer.sv
// Load and reserved items: one per cycle while full is low and the back end is idle, no result.
// Read item: tables read on dequeue, result registered when output is free; one read at a time.
// Run item: walks each vertex, upward edge and neighbour pair, scans the head's edge list
// and relaxes each triangle found; result registered after the walk, one run at a time.
// After reset the witness tables are cleared, with full high until clearing ends.
// Reset: asynchronous, active low; vertex_count and missing-edge flag cleared.
module cch_triangle_customizer #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cch_tc_pkg::VC_W-1:0]   cfg_wdata,
	input  logic                          push,
	output logic                          full,
	input  logic [cch_tc_pkg::REQ_W-1:0]  req_type,
	input  logic [cch_tc_pkg::IDX_W-1:0]  item_index,
	input  logic [cch_tc_pkg::IDX_W-1:0]  offset_value,
	input  logic [cch_tc_pkg::HEAD_W-1:0] edge_head,
	input  logic [cch_tc_pkg::WIN_W-1:0]  up_weight_in,
	input  logic [cch_tc_pkg::WIN_W-1:0]  down_weight_in,
	output logic                          empty,
	input  logic                          pop,
	output logic                          status,
	output logic [cch_tc_pkg::WIN_W-1:0]  up_weight_out,
	output logic [cch_tc_pkg::WIN_W-1:0]  down_weight_out,
	output logic [cch_tc_pkg::IDX_W-1:0]  up_via_first,
	output logic [cch_tc_pkg::IDX_W-1:0]  up_via_second,
	output logic [cch_tc_pkg::IDX_W-1:0]  down_via_first,
	output logic [cch_tc_pkg::IDX_W-1:0]  down_via_second
);

	logic [cch_tc_pkg::VC_W-1:0] vertex_count_q;
	logic                        cmd_valid;
	logic                        cmd_pop;
	cch_tc_pkg::cmd_t            cmd;
	cch_tc_pkg::back_stat_t      stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	cch_tc_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES(MAX_EDGES)
	) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .item_index(item_index), .offset_value(offset_value),
		.edge_head(edge_head), .up_weight_in(up_weight_in),
		.down_weight_in(down_weight_in), .stat(stat),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	cch_tc_back #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES(MAX_EDGES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .vertex_count(vertex_count_q),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .stat(stat),
		.empty(empty), .pop(pop), .status(status),
		.up_weight_out(up_weight_out), .down_weight_out(down_weight_out),
		.up_via_first(up_via_first), .up_via_second(up_via_second),
		.down_via_first(down_via_first), .down_via_second(down_via_second)
	);

endmodule
